/* hw/rtl/receive_reorder_window_core_defines.svh */
`ifndef RECEIVE_REORDER_WINDOW_CORE_DEFINES_SVH
`define RECEIVE_REORDER_WINDOW_CORE_DEFINES_SVH
`ifndef SYNTH
`define RRW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define RRW_ASSERT(lbl, clk, rst, prop, msg)
`define RRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/rrw_pkg.sv */
package rrw_pkg;

   localparam int WINDOW_SLOTS = 32;
   localparam int SLOT_AW      = $clog2(WINDOW_SLOTS);
   localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);
   localparam int SEQ_W        = 32;
   localparam int PAYLOAD_W    = 16;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   typedef struct packed {
      logic                 is_timeout;
      logic [SEQ_W-1:0]     seg_seq;
      logic [PAYLOAD_W-1:0] payload_id;
   } req_type;

   typedef struct packed {
      logic                 kind;
      logic [SEQ_W-1:0]     out_seq;
      logic [PAYLOAD_W-1:0] out_payload;
      logic [SEQ_W-1:0]     ack_value;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_AW-1:0]   wr_addr;
      logic [PAYLOAD_W-1:0] wr_data;
      logic                 rd_en;
      logic [SLOT_AW-1:0]   rd_addr;
      logic                 clr_all;
   } slot_cmd_type;

endpackage

/* hw/rtl/receive_reorder_window_core.sv */
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | req_type (is_timeout, seg_seq, payload_id)
// rsp     | out       | rsp_valid/rsp_stall | rsp_type (kind, out_seq, out_payload, ...)
// csr     | in        | csr_valid/csr_ready | initial_expected_seq
//
// one transaction at a time: an accept step, a classify step, then per
// delivered slot one payload memory read and one output load, a step that finds the
// end of the run and a step for the ack
// slots sit in a circular payload memory indexed by the low sequence bits
// synchronous reset, no clearing pass; rsp_stall holds the output register and
// the sequencer waits on it
`include "receive_reorder_window_core_defines.svh"

module receive_reorder_window_core
   import rrw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [SEQ_W-1:0] csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLASS = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_ACK   = 3'd4;

   logic [2:0]       state_ff, state_in;
   req_type          item_ff, item_in;
   logic [SEQ_W-1:0] exp_ff, exp_in;
   logic [SEQ_W-1:0] dseq_ff, dseq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             gap_ff, gap_in;
   logic             is_eq_ff, is_eq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   slot_cmd_type            cmd;
   logic [PAYLOAD_W-1:0]    rd_data;
   logic [WINDOW_SLOTS-1:0] valid_vec;
   logic [SEQ_W-1:0]        seq_dist;
   logic [SLOT_AW-1:0]      head_idx;
   logic                    head_valid;
   logic                    rsp_free;
   logic                    in_idle;
   logic                    csr_wr;

   rrw_slot_store u_slot_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_data (rd_data),
      .valid   (valid_vec)
   );

   assign seq_dist   = item_ff.seg_seq - exp_ff;
   assign head_idx   = exp_ff[SLOT_AW-1:0];
   assign head_valid = valid_vec[head_idx];
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign in_idle    = (state_ff == S_IDLE);
   assign csr_wr     = csr_valid && csr_ready;

   assign csr_ready = in_idle;
   assign req_stall = !in_idle || csr_valid;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      exp_in       = exp_ff;
      dseq_in      = dseq_ff;
      cnt_in       = cnt_ff;
      gap_in       = gap_ff;
      is_eq_in     = is_eq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;

      case (state_ff)
         S_IDLE: begin
            if (csr_wr) begin
               exp_in      = csr_data;
               gap_in      = 1'b0;
               cmd.clr_all = 1'b1;
            end else if (req_valid) begin
               item_in  = req_data;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            cnt_in   = '0;
            is_eq_in = 1'b0;
            if (item_ff.is_timeout) begin
               state_in = head_valid ? S_READ : S_IDLE;
            end else if (seq_dist == '0) begin
               if (head_valid) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = head_idx;
                  cmd.wr_data = item_ff.payload_id;
                  is_eq_in    = 1'b1;
                  state_in    = S_READ;
               end
            end else if (!seq_dist[SEQ_W-1]) begin
               gap_in = 1'b1;
               if (seq_dist < SEQ_W'(WINDOW_SLOTS)) begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = item_ff.seg_seq[SLOT_AW-1:0];
                  cmd.wr_data = item_ff.payload_id;
               end
               state_in = S_ACK;
            end else begin
               state_in = S_ACK;
            end
         end
         S_READ: begin
            if ((cnt_ff < CNT_W'(WINDOW_SLOTS)) && head_valid) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = head_idx;
               dseq_in     = exp_ff;
               exp_in      = exp_ff + SEQ_W'(1);
               cnt_in      = cnt_ff + CNT_W'(1);
               state_in    = S_EMIT;
            end else begin
               if (is_eq_ff) begin
                  gap_in = |valid_vec;
               end
               state_in = S_ACK;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = KIND_DATA;
               rsp_data_in.out_seq     = dseq_ff;
               rsp_data_in.out_payload = rd_data;
               rsp_data_in.ack_value   = '0;
               rsp_data_in.last        = 1'b0;
               state_in                = S_READ;
            end
         end
         S_ACK: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = KIND_ACK;
               rsp_data_in.out_seq     = '0;
               rsp_data_in.out_payload = '0;
               rsp_data_in.ack_value   = exp_ff;
               rsp_data_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         exp_ff       <= '0;
         cnt_ff       <= '0;
         gap_ff       <= 1'b0;
         is_eq_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         cnt_ff       <= cnt_in;
         gap_ff       <= gap_in;
         is_eq_ff     <= is_eq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dseq_ff     <= dseq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // between transactions the head slot is always empty
   `RRW_ASSERT(a_idle_head, clock, reset, in_idle |-> !head_valid, "head valid while idle")
   // while idle, a clear gap flag means no slot is held
   `RRW_ASSERT(a_gap_slots, clock, reset, in_idle && !gap_ff |-> valid_vec == '0, "gap flag low")
   `RRW_ASSERT(a_run_bound, clock, reset, cnt_ff <= CNT_W'(WINDOW_SLOTS), "run too long")
   `RRW_ASSERT_NEXT(a_csr_seq, clock, reset, csr_wr, exp_ff == $past(csr_data), "seq not loaded")
   `RRW_ASSERT_NEXT(a_csr_clr, clock, reset, csr_wr, !gap_ff && valid_vec == '0, "not cleared")

endmodule

/* hw/rtl/rrw_slot_store.sv */
module rrw_slot_store
   import rrw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  slot_cmd_type            cmd,
   output logic [PAYLOAD_W-1:0]    rd_data,
   output logic [WINDOW_SLOTS-1:0] valid
);

   logic [PAYLOAD_W-1:0]    payload_mem [WINDOW_SLOTS];
   logic [PAYLOAD_W-1:0]    rd_data_ff;
   logic [WINDOW_SLOTS-1:0] valid_ff;
   logic [WINDOW_SLOTS-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         payload_mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= payload_mem[cmd.rd_addr];
      end
   end

   // a write sets a slot's valid bit; a read drains the slot, so its valid bit drops with it; clr_all clears every bit
   always_comb begin
      valid_in = valid_ff;
      if (cmd.clr_all) begin
         valid_in = '0;
      end else begin
         if (cmd.wr_en) begin
            valid_in[cmd.wr_addr] = 1'b1;
         end
         if (cmd.rd_en) begin
            valid_in[cmd.rd_addr] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign valid   = valid_ff;

endmodule
